// ----- rtl/xcl_pkg.sv -----
// xcl_pkg: shared types and codes for the xml context lexer
// holds the item structs, token/context/status codes and the lexer state record
// no dependencies
package xcl_pkg;

  typedef enum logic [3:0] {
    KIND_WS        = 4'd0,
    KIND_TAGSTART  = 4'd1,
    KIND_TAGEND    = 4'd2,
    KIND_DECLSTART = 4'd3,
    KIND_DECLEND   = 4'd4,
    KIND_NAME      = 4'd5,
    KIND_SYMBOL    = 4'd6,
    KIND_QUOTED    = 4'd7,
    KIND_CONTENT   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    CTX_CONTENT = 2'd0,
    CTX_TAG     = 2'd1,
    CTX_DECL    = 2'd2
  } ctx_e;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_LT   = 2'd1,
    HOLD_QM   = 2'd2
  } hold_e;

  typedef enum logic [1:0] {
    STAT_TOKEN = 2'd0,
    STAT_ERROR = 2'd1,
    STAT_EOS   = 2'd2
  } status_e;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // result queue depth, must hold two results per item plus the one in flight
  localparam int unsigned XCL_FIFO_DEPTH = 4;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } xcl_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] token_kind;
    logic       first_of_token;
    logic [1:0] status;
    logic [1:0] context_after;
    logic       last_of_run;
  } xcl_out_t;

  typedef struct packed {
    ctx_e  context_mode;
    kind_e open_kind;
    logic  token_open;
    logic  escape_next;
    hold_e held_symbol;
    logic  error_halt;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RESET = '{
    context_mode: CTX_CONTENT,
    open_kind:    KIND_WS,
    token_open:   1'b0,
    escape_next:  1'b0,
    held_symbol:  HOLD_NONE,
    error_halt:   1'b0
  };

  // results of one item: 0, 1 or 2 entries, res0 first
  typedef struct packed {
    logic [1:0] count;
    xcl_out_t   res0;
    xcl_out_t   res1;
  } lex_res_t;

endpackage

// ----- rtl/xcl_lexer.sv -----
// xcl_lexer: combinational lexing of one item against the current lexer state
// produces the next state and up to two results
// depends on xcl_pkg
module xcl_lexer (
  input  xcl_pkg::lex_state_t state_i,
  input  xcl_pkg::xcl_in_t    item_i,
  output xcl_pkg::lex_state_t state_o,
  output xcl_pkg::lex_res_t   res_o
);
  import xcl_pkg::*;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    lex_state_t st;
    logic       valid;
    xcl_out_t   res;
  } step_t;

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic logic is_name(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h5F;
  endfunction

  function automatic xcl_out_t mk(logic [7:0] b, kind_e kind, logic first,
                                  status_e stat, ctx_e ctx);
    xcl_out_t r;
    r.out_byte       = b;
    r.token_kind     = kind;
    r.first_of_token = first;
    r.status         = stat;
    r.context_after  = ctx;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // whitespace and name runs continue an open token of the same kind
  function automatic step_t run_token(lex_state_t s, logic [7:0] b, kind_e kind);
    step_t o;
    logic  first;
    first        = !(s.token_open && s.open_kind == kind);
    o.st         = s;
    o.st.token_open = 1'b1;
    o.st.open_kind  = kind;
    o.valid      = 1'b1;
    o.res        = mk(b, kind, first, STAT_TOKEN, s.context_mode);
    return o;
  endfunction

  function automatic step_t lex_byte(lex_state_t s, logic [7:0] b);
    step_t o;
    o.st    = s;
    o.valid = 1'b0;
    o.res   = mk(b, KIND_WS, 1'b0, STAT_TOKEN, s.context_mode);
    if (s.context_mode != CTX_TAG && s.context_mode != CTX_DECL) begin
      if (b == CH_LT) begin
        o.st.token_open  = 1'b0;
        o.st.held_symbol = HOLD_LT;
      end else if (s.token_open && s.open_kind == KIND_CONTENT) begin
        o.valid = 1'b1;
        o.res   = mk(b, KIND_CONTENT, 1'b0, STAT_TOKEN, s.context_mode);
      end else if (is_ws(b)) begin
        o = run_token(s, b, KIND_WS);
      end else begin
        o.st.token_open = 1'b1;
        o.st.open_kind  = KIND_CONTENT;
        o.valid         = 1'b1;
        o.res           = mk(b, KIND_CONTENT, 1'b1, STAT_TOKEN, s.context_mode);
      end
    end else if (s.token_open && s.open_kind == KIND_QUOTED) begin
      if (s.escape_next) begin
        o.st.escape_next = 1'b0;
      end else if (b == CH_BSL) begin
        o.st.escape_next = 1'b1;
      end else if (b == CH_DQ) begin
        o.st.token_open = 1'b0;
      end
      o.valid = 1'b1;
      o.res   = mk(b, KIND_QUOTED, 1'b0, STAT_TOKEN, s.context_mode);
    end else if (b == CH_DQ) begin
      o.st.token_open  = 1'b1;
      o.st.open_kind   = KIND_QUOTED;
      o.st.escape_next = 1'b0;
      o.valid          = 1'b1;
      o.res            = mk(b, KIND_QUOTED, 1'b1, STAT_TOKEN, s.context_mode);
    end else if (is_ws(b)) begin
      o = run_token(s, b, KIND_WS);
    end else if (is_name(b)) begin
      o = run_token(s, b, KIND_NAME);
    end else if (b == CH_EQ) begin
      o.st.token_open = 1'b0;
      o.valid         = 1'b1;
      o.res           = mk(b, KIND_SYMBOL, 1'b1, STAT_TOKEN, s.context_mode);
    end else if (s.context_mode == CTX_TAG && b == CH_GT) begin
      o.st.token_open   = 1'b0;
      o.st.context_mode = CTX_CONTENT;
      o.valid           = 1'b1;
      o.res             = mk(b, KIND_TAGEND, 1'b1, STAT_TOKEN, CTX_CONTENT);
    end else if (s.context_mode == CTX_DECL && b == CH_QM) begin
      o.st.token_open  = 1'b0;
      o.st.held_symbol = HOLD_QM;
    end else begin
      o.st.token_open = 1'b0;
      o.st.error_halt = 1'b1;
      o.valid         = 1'b1;
      o.res           = mk(b, KIND_WS, 1'b0, STAT_ERROR, s.context_mode);
    end
    return o;
  endfunction

  lex_state_t st;
  logic       pre_v;
  xcl_out_t   pre;
  step_t      lex;
  logic [7:0] b;

  always_comb begin
    b     = item_i.in_byte;
    st    = state_i;
    pre_v = 1'b0;
    pre   = mk(CH_LT, KIND_TAGSTART, 1'b1, STAT_TOKEN, CTX_TAG);
    lex.st    = state_i;
    lex.valid = 1'b0;
    lex.res   = mk(b, KIND_WS, 1'b0, STAT_TOKEN, state_i.context_mode);

    if (item_i.command == CMD_EOS) begin
      // flush a held lookahead byte, then report end of stream
      pre_v = (state_i.held_symbol != HOLD_NONE);
      if (state_i.held_symbol == HOLD_QM) begin
        pre = mk(CH_QM, KIND_SYMBOL, 1'b1, STAT_TOKEN, CTX_DECL);
      end
      lex.st    = LEX_STATE_RESET;
      lex.valid = 1'b1;
      lex.res   = mk(CH_NUL, KIND_WS, 1'b0, STAT_EOS, CTX_CONTENT);
    end else if (!state_i.error_halt) begin
      unique case (state_i.held_symbol)
        HOLD_LT: begin
          st.held_symbol = HOLD_NONE;
          st.token_open  = 1'b0;
          pre_v          = 1'b1;
          if (b == CH_SLASH) begin
            st.context_mode = CTX_TAG;
            lex.st    = st;
            lex.valid = 1'b1;
            lex.res   = mk(b, KIND_TAGSTART, 1'b0, STAT_TOKEN, CTX_TAG);
          end else if (b == CH_QM) begin
            st.context_mode = CTX_DECL;
            pre       = mk(CH_LT, KIND_DECLSTART, 1'b1, STAT_TOKEN, CTX_DECL);
            lex.st    = st;
            lex.valid = 1'b1;
            lex.res   = mk(b, KIND_DECLSTART, 1'b0, STAT_TOKEN, CTX_DECL);
          end else begin
            st.context_mode = CTX_TAG;
            lex = lex_byte(st, b);
          end
        end
        HOLD_QM: begin
          st.held_symbol = HOLD_NONE;
          st.token_open  = 1'b0;
          pre_v          = 1'b1;
          if (b == CH_GT) begin
            st.context_mode = CTX_CONTENT;
            pre       = mk(CH_QM, KIND_DECLEND, 1'b1, STAT_TOKEN, CTX_CONTENT);
            lex.st    = st;
            lex.valid = 1'b1;
            lex.res   = mk(b, KIND_DECLEND, 1'b0, STAT_TOKEN, CTX_CONTENT);
          end else begin
            pre = mk(CH_QM, KIND_SYMBOL, 1'b1, STAT_TOKEN, state_i.context_mode);
            lex = lex_byte(st, b);
          end
        end
        default: begin
          lex = lex_byte(st, b);
        end
      endcase
    end
  end

  always_comb begin
    state_o     = lex.st;
    res_o.count = {1'b0, pre_v} + {1'b0, lex.valid};
    res_o.res0  = pre_v ? pre : lex.res;
    res_o.res1  = lex.res;
    // the final result of the item carries the last mark
    if (pre_v && lex.valid) begin
      res_o.res1.last_of_run = 1'b1;
    end else begin
      res_o.res0.last_of_run = 1'b1;
    end
  end

endmodule

// ----- rtl/xcl_result_fifo.sv -----
// xcl_result_fifo: small result queue that takes up to two results per cycle
// and hands out one per cycle at the output handshake
// depends on xcl_pkg
module xcl_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xcl_pkg::lex_res_t push_i,
  output logic              room2_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output xcl_pkg::xcl_out_t out_item_o
);
  import xcl_pkg::*;

  localparam int unsigned PtrW = $clog2(XCL_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(XCL_FIFO_DEPTH + 1);

  xcl_out_t          mem_q [XCL_FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;
  logic [PtrW-1:0]   wr_ptr_nx;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= CntW'(XCL_FIFO_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

endmodule

// ----- rtl/xml_context_lexer.sv -----
// xml_context_lexer: byte-wise xml lexer with content, tag and declaration contexts
// top level: input register, lexer state, combinational lexer and result queue
// depends on xcl_pkg, xcl_lexer, xcl_result_fifo
//
// usage:
//   input channel: in_valid_i / in_stall_o with in_item_i (command, in_byte).
//   command data lexes one byte, command end of stream flushes any held
//   lookahead byte, reports end of stream and returns the lexer to reset.
//   output channel: out_valid_o / out_stall_i with out_item_o; each item
//   gives zero, one or two results, the final one with last_of_run set.
//   path: an accepted item waits in the input register until the queue has
//   room for two results, is then lexed, and its results are written into
//   the result queue, from which they are offered on the output channel.
//   throughput: one item per cycle while each item gives at most one result
//   and the receiver does not stall; an item with two results hands them out
//   one at a time through the single output port of the four-entry result queue.
//   stall: the item in the input register is lexed only when the queue has
//   room for two results, so a stalled receiver backs up into in_stall_o;
//   no item or result is dropped.
//   reset: asynchronous, active low; clears the lexer state to content
//   context and empties both the input register and the result queue.
module xml_context_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  xcl_pkg::xcl_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output xcl_pkg::xcl_out_t out_item_o
);
  import xcl_pkg::*;

  logic       in_valid_q, in_valid_d;
  xcl_in_t    in_item_q;
  lex_state_t state_q, state_d;
  lex_res_t   lex_res;
  lex_res_t   push;
  logic       room2;
  logic       process;
  logic       accept;

  assign process    = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
    push = lex_res;
    if (!process) begin
      push.count = 2'd0;
    end
  end

  xcl_lexer u_lexer (
    .state_i (state_q),
    .item_i  (in_item_q),
    .state_o (state_d),
    .res_o   (lex_res)
  );

  xcl_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= LEX_STATE_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (process) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

endmodule
